@@ hw/rtl/kscu_pkg.sv @@
// shared types, constants and letter decode for the keyword substitution cipher unit
`timescale 1ns / 1ps

package kscu_pkg;

   localparam int LETTER_COUNT = 26;
   localparam int IDX_W        = 5;
   localparam int BYTE_W       = 8;
   localparam int CMD_W        = 2;

   localparam logic [BYTE_W-1:0] UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] UPPER_Z = 8'h5A;
   localparam logic [BYTE_W-1:0] LOWER_A = 8'h61;
   localparam logic [BYTE_W-1:0] LOWER_Z = 8'h7A;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR   = 2'd0,
      CMD_KEYWORD = 2'd1,
      CMD_FINISH  = 2'd2,
      CMD_TEXT    = 2'd3
   } cmd_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FINISH,
      ST_READ
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic clear;
      logic append_kw;
      logic walk_start;
      logic walk_step;
      logic text_issue;
      logic out_load;
   } dp_ctrl_type;

   // status from datapath to controller
   typedef struct packed {
      logic key_finished;
      logic walk_done;
      logic out_free;
   } dp_stat_type;

   typedef struct packed {
      logic             is_letter;
      logic             is_lower;
      logic [IDX_W-1:0] idx;
   } letter_type;

   function automatic letter_type decode_letter(input logic [BYTE_W-1:0] b);
      letter_type       r;
      logic [BYTE_W-1:0] du;
      logic [BYTE_W-1:0] dl;
      du = b - UPPER_A;
      dl = b - LOWER_A;
      r.is_letter = 1'b0;
      r.is_lower  = 1'b0;
      r.idx       = du[IDX_W-1:0];
      if (b >= UPPER_A && b <= UPPER_Z) begin
         r.is_letter = 1'b1;
      end else if (b >= LOWER_A && b <= LOWER_Z) begin
         r.is_letter = 1'b1;
         r.is_lower  = 1'b1;
         r.idx       = dl[IDX_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/kscu_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps

module kscu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/kscu_datapath.sv @@
// key build, table storage, text mapping and result register
`timescale 1ns / 1ps

module kscu_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  kscu_pkg::dp_ctrl_type        ctrl,
   output kscu_pkg::dp_stat_type        stat,
   input  logic [kscu_pkg::BYTE_W-1:0]  in_byte,
   input  logic                         csr_we,
   input  logic                         csr_wdata,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [kscu_pkg::BYTE_W-1:0]  out_byte,
   output logic                         out_key_ready
);

   import kscu_pkg::*;

   logic [LETTER_COUNT-1:0] letter_used_ff, letter_used_in;
   logic [IDX_W-1:0]        key_length_ff, key_length_in;
   logic                    key_finished_ff, key_finished_in;
   logic [IDX_W-1:0]        walk_ff, walk_in;
   logic [BYTE_W-1:0]       text_ff;
   logic                    decrypt_ff;
   logic                    out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]       out_byte_ff;
   logic                    out_key_ready_ff;

   letter_type       in_let;
   letter_type       text_let;
   logic             app_en;
   logic [IDX_W-1:0] app_idx;
   logic             rd_en;
   logic [IDX_W-1:0] fwd_rd;
   logic [IDX_W-1:0] inv_rd;
   logic [IDX_W-1:0] mapped;
   logic [BYTE_W-1:0] base;
   logic [BYTE_W-1:0] cipher_byte;

   assign in_let   = decode_letter(in_byte);
   assign text_let = decode_letter(text_ff);

   // one append source per cycle: keyword byte or finish walk
   always_comb begin
      app_en  = 1'b0;
      app_idx = in_let.idx;
      if (ctrl.append_kw) begin
         app_en = in_let.is_letter && !letter_used_ff[in_let.idx] && !key_finished_ff
                  && (key_length_ff < IDX_W'(LETTER_COUNT));
      end else if (ctrl.walk_step) begin
         app_idx = walk_ff;
         app_en  = !letter_used_ff[walk_ff] && (key_length_ff < IDX_W'(LETTER_COUNT));
      end
   end

   always_comb begin
      letter_used_in  = letter_used_ff;
      key_length_in   = key_length_ff;
      key_finished_in = key_finished_ff;
      walk_in         = walk_ff;
      if (ctrl.clear) begin
         letter_used_in  = '0;
         key_length_in   = '0;
         key_finished_in = 1'b0;
      end else begin
         if (app_en) begin
            letter_used_in[app_idx] = 1'b1;
            key_length_in           = key_length_ff + IDX_W'(1);
         end
         if (ctrl.walk_start) begin
            walk_in = IDX_W'(LETTER_COUNT - 1);
         end else if (ctrl.walk_step) begin
            walk_in = walk_ff - IDX_W'(1);
            if (walk_ff == '0) begin
               key_finished_in = 1'b1;
            end
         end
      end
   end

   // forward: position -> letter, inverse: letter -> position
   assign rd_en = ctrl.text_issue && in_let.is_letter;

   kscu_ram #(.WIDTH(IDX_W), .DEPTH(LETTER_COUNT)) u_fwd_ram (
      .clock   (clock),
      .wr_en   (app_en),
      .wr_addr (key_length_ff),
      .wr_data (app_idx),
      .rd_en   (rd_en),
      .rd_addr (in_let.idx),
      .rd_data (fwd_rd)
   );

   kscu_ram #(.WIDTH(IDX_W), .DEPTH(LETTER_COUNT)) u_inv_ram (
      .clock   (clock),
      .wr_en   (app_en),
      .wr_addr (app_idx),
      .wr_data (key_length_ff),
      .rd_en   (rd_en),
      .rd_addr (in_let.idx),
      .rd_data (inv_rd)
   );

   assign mapped      = decrypt_ff ? inv_rd : fwd_rd;
   assign base        = text_let.is_lower ? LOWER_A : UPPER_A;
   assign cipher_byte = base + {{(BYTE_W-IDX_W){1'b0}}, mapped};

   always_comb begin
      out_valid_in = out_valid_ff;
      if (ctrl.out_load) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         letter_used_ff  <= '0;
         key_length_ff   <= '0;
         key_finished_ff <= 1'b0;
         decrypt_ff      <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         letter_used_ff  <= letter_used_in;
         key_length_ff   <= key_length_in;
         key_finished_ff <= key_finished_in;
         out_valid_ff    <= out_valid_in;
         if (csr_we) begin
            decrypt_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      walk_ff <= walk_in;
      if (ctrl.text_issue) begin
         text_ff <= in_byte;
      end
      if (ctrl.out_load) begin
         out_byte_ff      <= (key_finished_ff && text_let.is_letter) ? cipher_byte : text_ff;
         out_key_ready_ff <= key_finished_ff;
      end
   end

   assign stat.key_finished = key_finished_ff;
   assign stat.walk_done    = (walk_ff == '0);
   assign stat.out_free     = !out_valid_ff || out_ready;

   assign out_valid     = out_valid_ff;
   assign out_byte      = out_byte_ff;
   assign out_key_ready = out_key_ready_ff;

`ifndef SYNTHESIS
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      key_length_ff <= IDX_W'(LETTER_COUNT))
      else $error("key length above letter count");

   a_len_matches_used: assert property (@(posedge clock) disable iff (reset)
      $countones(letter_used_ff) == int'(key_length_ff))
      else $error("key length disagrees with used letters");

   a_finished_full: assert property (@(posedge clock) disable iff (reset)
      key_finished_ff |-> (&letter_used_ff))
      else $error("key finished with letters missing");
`endif

endmodule

@@ hw/rtl/kscu_controller.sv @@
// controller state machine for command sequencing
`timescale 1ns / 1ps

module kscu_controller (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [kscu_pkg::CMD_W-1:0]   command,
   input  kscu_pkg::dp_stat_type        stat,
   output kscu_pkg::dp_ctrl_type        ctrl
);

   import kscu_pkg::*;

   state_type    state_ff, state_in;
   cmd_code_type cmd;

   assign cmd = cmd_code_type'(command);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (cmd)
                  CMD_CLEAR:   ctrl.clear = 1'b1;
                  CMD_KEYWORD: ctrl.append_kw = 1'b1;
                  CMD_FINISH: begin
                     if (!stat.key_finished) begin
                        ctrl.walk_start = 1'b1;
                        state_in        = ST_FINISH;
                     end
                  end
                  CMD_TEXT: begin
                     ctrl.text_issue = 1'b1;
                     state_in        = ST_READ;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_FINISH: begin
            ctrl.walk_step = 1'b1;
            if (stat.walk_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            if (stat.out_free) begin
               ctrl.out_load = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ hw/rtl/keyword_substitution_cipher_unit.sv @@
// top level of the keyword substitution cipher unit
`timescale 1ns / 1ps

// Builds a 26-letter substitution key from keyword words and then ciphers
// text words through it. Each input word carries a command in req_tuser:
// clear key, keyword byte, finish key, or text byte; only a text byte gives
// a result word. Clear and keyword words act in their accept cycle. Finish walks
// the letters from Z down to A, one letter a cycle, appending the unused
// ones. Both forward and inverse tables are written as each letter is
// appended, so no separate inverse pass is needed. A text word's accept
// cycle launches the registered table ram read, and the result register is
// loaded once it is free. The result register lets the next word be
// accepted while a result still waits on rsp_tready. Text that arrives
// before the key is finished passes through unchanged with key_ready low.
// csr_wdata selects decrypt (1) or encrypt (0) and must only be written
// while the unit is idle.
module keyword_substitution_cipher_unit (
   input  logic       clock,
   input  logic       reset,
   // input words
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic [1:0] req_tuser,   // [1:0] command
   // result words
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tuser,   // [0] key_ready
   // decrypt_mode register
   input  logic       csr_we,
   input  logic       csr_wdata
);

   import kscu_pkg::*;

   dp_ctrl_type ctrl;
   dp_stat_type stat;

   // sequencing of commands, finish walk and table read
   kscu_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .command   (req_tuser),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   // key state, tables and result register
   kscu_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .stat          (stat),
      .in_byte       (req_tdata),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_byte      (rsp_tdata),
      .out_key_ready (rsp_tuser)
   );

endmodule
